FILE: rtl/core/ugrm_pkg.sv
// Package for the UTF-8 glyph run mapper: shared types, register map, the
// upper character map table and its lookup function. No dependencies.
`default_nettype none

package ugrm_pkg;

  localparam int MAP_ENTRIES = 128;
  localparam int MAP_POS_W   = $clog2(MAP_ENTRIES);
  localparam int CP_W        = 21;
  localparam int GLYPH_W     = 8;
  localparam int IDX_W       = 9;
  localparam int WORD_W      = 16;
  localparam int PADDR_W     = 4;
  localparam int PDATA_W     = 32;
  localparam int CAP_W       = 13;

  localparam logic [GLYPH_W-1:0] FIRST_CHAR_RST = 8'd0;
  localparam logic [GLYPH_W-1:0] LAST_CHAR_RST  = 8'd255;
  localparam logic [CAP_W-1:0]   RUN_CAP_RST    = 13'd64;

  typedef enum logic [1:0] {
    OP_LOAD_WO   = 2'd0,
    OP_LOAD_BL   = 2'd1,
    OP_TEXT      = 2'd2,
    OP_END       = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    REG_FIRST_CHAR   = 2'd0,
    REG_LAST_CHAR    = 2'd1,
    REG_RUN_CAPACITY = 2'd2
  } reg_idx_e;

  typedef struct packed {
    logic [GLYPH_W-1:0] first_char;
    logic [GLYPH_W-1:0] last_char;
    logic [CAP_W-1:0]   run_capacity;
  } cfg_t;

  typedef struct packed {
    logic               wo_we;
    logic               bl_we;
    logic [IDX_W-1:0]   wr_addr;
    logic [WORD_W-1:0]  wr_data;
    logic               rd_en;
    logic [GLYPH_W-1:0] rd_idx;
  } store_req_t;

  typedef struct packed {
    logic [WORD_W-1:0] wo_word;
    logic [WORD_W-1:0] bl_start;
    logic [WORD_W-1:0] bl_next;
  } store_rsp_t;

  typedef struct packed {
    logic                 hit;
    logic [MAP_POS_W-1:0] pos;
  } map_hit_t;

  localparam logic [WORD_W-1:0] UPPER_MAP [MAP_ENTRIES] = '{
    16'h00C4, 16'h00C5, 16'h00C7, 16'h00C9, 16'h00D1, 16'h00D6, 16'h00DC, 16'h00E1,
    16'h00E0, 16'h00E2, 16'h00E4, 16'h00E3, 16'h00E5, 16'h00E7, 16'h00E9, 16'h00E8,
    16'h00EA, 16'h00EB, 16'h00ED, 16'h00EC, 16'h00EE, 16'h00EF, 16'h00F1, 16'h00F3,
    16'h00F2, 16'h00F4, 16'h00F6, 16'h00F5, 16'h00FA, 16'h00F9, 16'h00FB, 16'h00FC,
    16'h2020, 16'h00B0, 16'h00A2, 16'h00A3, 16'h00A7, 16'h2022, 16'h00B6, 16'h00DF,
    16'h00AE, 16'h00A9, 16'h2122, 16'h00B4, 16'h00A8, 16'h2260, 16'h00C6, 16'h00D8,
    16'h221E, 16'h00B1, 16'h2264, 16'h2265, 16'h00A5, 16'h00B5, 16'h2202, 16'h2211,
    16'h220F, 16'h03C0, 16'h222B, 16'h00AA, 16'h00BA, 16'h03A9, 16'h00E6, 16'h00F8,
    16'h00BF, 16'h00A1, 16'h00AC, 16'h221A, 16'h0192, 16'h2248, 16'h2206, 16'h00AB,
    16'h00BB, 16'h2026, 16'h00A0, 16'h00C0, 16'h00C3, 16'h00D5, 16'h0152, 16'h0153,
    16'h2013, 16'h2014, 16'h201C, 16'h201D, 16'h2018, 16'h2019, 16'h00F7, 16'h25CA,
    16'h00FF, 16'h0178, 16'h2044, 16'h20AC, 16'h2039, 16'h203A, 16'hFB01, 16'hFB02,
    16'h2021, 16'h00B7, 16'h201A, 16'h201E, 16'h2030, 16'h00C2, 16'h00CA, 16'h00C1,
    16'h00CB, 16'h00C8, 16'h00CD, 16'h00CE, 16'h00CF, 16'h00CC, 16'h00D3, 16'h00D4,
    16'hF8FF, 16'h00D2, 16'h00DA, 16'h00DB, 16'h00D9, 16'h0131, 16'h02C6, 16'h02DC,
    16'h00AF, 16'h02D8, 16'h02D9, 16'h02DA, 16'h00B8, 16'h02DD, 16'h02DB, 16'h02C7
  };

  // Entries are distinct, so at most one compare matches.
  function automatic map_hit_t map_upper(input logic [WORD_W-1:0] cp);
    map_hit_t r;
    r = '{hit: 1'b0, pos: '0};
    for (int i = 0; i < MAP_ENTRIES; i++) begin
      if (UPPER_MAP[i] == cp) begin
        r.hit = 1'b1;
        r.pos = MAP_POS_W'(i);
      end
    end
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/core/ugrm_if.sv
// Valid/ready channel interfaces for the glyph run mapper input and result
// streams. Depends on ugrm_pkg.
`default_nettype none

interface ugrm_in_if;
  logic              valid;
  logic              ready;
  ugrm_pkg::op_e     op;
  logic [8:0]        table_index;
  logic [15:0]       table_word;
  logic [7:0]        text_byte;

  modport source (output valid, op, table_index, table_word, text_byte, input ready);
  modport sink   (input valid, op, table_index, table_word, text_byte, output ready);
endinterface

interface ugrm_out_if;
  logic              valid;
  logic              ready;
  logic [7:0]        glyph_code;
  logic signed [7:0] advance;
  logic signed [7:0] left_offset;
  logic [15:0]       bitmap_start;
  logic [15:0]       bitmap_width;
  logic              end_of_run;

  modport source (output valid, glyph_code, advance, left_offset, bitmap_start,
                  bitmap_width, end_of_run, input ready);
  modport sink   (input valid, glyph_code, advance, left_offset, bitmap_start,
                  bitmap_width, end_of_run, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/utf8_glyph_run_mapper.sv
// Glyph run mapper: UTF-8 text bytes in, run entries out.
// Channels: in_chan_i (op, table_index, table_word, text_byte) and out_chan_o
// (glyph_code, advance, left_offset, bitmap_start, bitmap_width, end_of_run),
// both valid/ready; an APB-style port holds first_char, last_char and
// run_capacity at byte addresses 0, 4 and 8.
// Load ops write the width/offset or bitmap location store and give no
// result. A text byte is decoded, mapped to a glyph code and, when in the
// font and the run is not full, reads both stores; the entry is shown in the
// cycle after the transaction. An end op gives the terminator entry and
// clears the run and any partial sequence.
// Throughput: one transaction per cycle. Decode, map and range check sit in
// the accept cycle; the store read fills the output register in the next cycle.
// A result held by a stalled receiver blocks input only while it is still
// waiting; a new transaction is taken in the cycle the waiting result is taken.
// Reset: configuration returns to 0 / 255 / 64, the run and decoder are
// cleared. Stores are not cleared and must be loaded before use.
// Depends on ugrm_pkg, ugrm_if, ugrm_cfg, ugrm_utf8_dec, ugrm_glyph_store.
`default_nettype none

module utf8_glyph_run_mapper #(
  parameter int GLYPH_SLOTS = 256,
  parameter int MAX_RUN     = 4096
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  ugrm_in_if.sink                       in_chan_i,
  ugrm_out_if.source                    out_chan_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ugrm_pkg::PADDR_W-1:0]  paddr,
  input  logic [ugrm_pkg::PDATA_W-1:0]  pwdata,
  output logic [ugrm_pkg::PDATA_W-1:0]  prdata,
  output logic                          pready
);
  import ugrm_pkg::*;

  localparam int CNT_W = $clog2(MAX_RUN);
  localparam logic [16:0] MAX_RUN_X = 17'(MAX_RUN);

  cfg_t               cfg;
  store_req_t         st_req;
  store_rsp_t         st_rsp;
  map_hit_t           up_hit;

  logic               in_ready, in_acc, is_text, is_end;
  logic               cp_valid, full_now, dec_step, emit;
  logic [CP_W-1:0]    cp;
  logic               map_hit, in_range, in_slots;
  logic [GLYPH_W-1:0] glyph, idx;
  logic [16:0]        cap_x, limit_x;
  logic [CNT_W-1:0]   limit, cnt_q, cnt_d, cnt_inc;
  logic               run_full_q, run_full_d;
  logic               s1_valid_q, s1_end_q;
  logic [GLYPH_W-1:0] s1_glyph_q;

  ugrm_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  assign in_ready        = !s1_valid_q || out_chan_o.ready;
  assign in_chan_i.ready = in_ready;
  assign in_acc          = in_chan_i.valid && in_ready;
  assign is_text         = in_chan_i.op == OP_TEXT;
  assign is_end          = in_chan_i.op == OP_END;

  // run limit is capacity minus one, with capacity clamped to [2, MAX_RUN]
  assign cap_x = {4'b0, cfg.run_capacity};
  always_comb begin
    if (cap_x < 17'd2) begin
      limit_x = 17'd1;
    end else if (cap_x > MAX_RUN_X) begin
      limit_x = MAX_RUN_X - 17'd1;
    end else begin
      limit_x = cap_x - 17'd1;
    end
  end
  assign limit    = limit_x[CNT_W-1:0];
  assign full_now = run_full_q || (cnt_q >= limit);
  assign dec_step = in_acc && is_text && !full_now;

  ugrm_utf8_dec u_dec (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .step_i     (dec_step),
    .clear_i    (in_acc && is_end),
    .byte_i     (in_chan_i.text_byte),
    .cp_valid_o (cp_valid),
    .cp_o       (cp)
  );

  assign up_hit = map_upper(cp[WORD_W-1:0]);
  always_comb begin
    map_hit = 1'b0;
    glyph   = {1'b1, up_hit.pos};
    if (cp[CP_W-1:7] == '0) begin
      map_hit = 1'b1;
      glyph   = cp[GLYPH_W-1:0];
    end else if (cp[CP_W-1:WORD_W] == '0) begin
      map_hit = up_hit.hit;
    end
  end

  assign in_range = glyph >= cfg.first_char && glyph <= cfg.last_char;
  assign idx      = glyph - cfg.first_char;
  assign in_slots = {1'b0, idx} < 9'(GLYPH_SLOTS);
  assign emit     = dec_step && cp_valid && map_hit && in_range && in_slots;

  assign st_req.wo_we   = in_acc && in_chan_i.op == OP_LOAD_WO;
  assign st_req.bl_we   = in_acc && in_chan_i.op == OP_LOAD_BL;
  assign st_req.wr_addr = in_chan_i.table_index;
  assign st_req.wr_data = in_chan_i.table_word;
  assign st_req.rd_en   = emit;
  assign st_req.rd_idx  = idx;

  ugrm_glyph_store #(
    .GLYPH_SLOTS (GLYPH_SLOTS)
  ) u_store (
    .clk_i (clk_i),
    .req_i (st_req),
    .rsp_o (st_rsp)
  );

  assign cnt_inc = cnt_q + 1'b1;
  always_comb begin
    cnt_d      = cnt_q;
    run_full_d = run_full_q;
    if (in_acc && is_end) begin
      cnt_d      = '0;
      run_full_d = 1'b0;
    end else if (in_acc && is_text) begin
      run_full_d = full_now;
      if (emit) begin
        cnt_d      = cnt_inc;
        run_full_d = cnt_inc >= limit;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q      <= '0;
      run_full_q <= 1'b0;
      s1_valid_q <= 1'b0;
    end else begin
      cnt_q      <= cnt_d;
      run_full_q <= run_full_d;
      if (in_ready) begin
        s1_valid_q <= in_acc && (is_end || emit);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_end_q   <= is_end;
      s1_glyph_q <= glyph;
    end
  end

  assign out_chan_o.valid        = s1_valid_q;
  assign out_chan_o.end_of_run   = s1_end_q;
  assign out_chan_o.glyph_code   = s1_end_q ? '0 : s1_glyph_q;
  assign out_chan_o.advance      = s1_end_q ? '0 : st_rsp.wo_word[7:0];
  assign out_chan_o.left_offset  = s1_end_q ? '0 : st_rsp.wo_word[15:8];
  assign out_chan_o.bitmap_start = s1_end_q ? '0 : st_rsp.bl_start;
  assign out_chan_o.bitmap_width = s1_end_q ? '0 : st_rsp.bl_next - st_rsp.bl_start;

`ifndef NO_ASSERTIONS
  a_no_phantom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready && !in_acc |=> !s1_valid_q)
    else $error("result without an accepted transaction");

  a_end_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && is_end |=> cnt_q == '0 && !run_full_q)
    else $error("end of text did not clear the run");

  a_cnt_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q != $past(cnt_q) |-> (cnt_q == $past(cnt_q) + 1'b1) || (cnt_q == '0))
    else $error("entry count moved by more than one");
`endif

endmodule

`default_nettype wire

FILE: rtl/core/ugrm_cfg.sv
// APB-style configuration registers of the glyph run mapper.
// Depends on ugrm_pkg.
`default_nettype none

module ugrm_cfg (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ugrm_pkg::PADDR_W-1:0]  paddr,
  input  logic [ugrm_pkg::PDATA_W-1:0]  pwdata,
  output logic [ugrm_pkg::PDATA_W-1:0]  prdata,
  output logic                          pready,
  output ugrm_pkg::cfg_t                cfg_o
);
  import ugrm_pkg::*;

  cfg_t     cfg_q;
  logic     wr_en;
  reg_idx_e reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;
  assign reg_sel = reg_idx_e'(paddr[PADDR_W-1:2]);
  assign cfg_o   = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.first_char   <= FIRST_CHAR_RST;
      cfg_q.last_char    <= LAST_CHAR_RST;
      cfg_q.run_capacity <= RUN_CAP_RST;
    end else if (wr_en) begin
      unique case (reg_sel)
        REG_FIRST_CHAR:   cfg_q.first_char   <= pwdata[GLYPH_W-1:0];
        REG_LAST_CHAR:    cfg_q.last_char    <= pwdata[GLYPH_W-1:0];
        REG_RUN_CAPACITY: cfg_q.run_capacity <= pwdata[CAP_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (reg_sel)
      REG_FIRST_CHAR:   prdata = PDATA_W'(cfg_q.first_char);
      REG_LAST_CHAR:    prdata = PDATA_W'(cfg_q.last_char);
      REG_RUN_CAPACITY: prdata = PDATA_W'(cfg_q.run_capacity);
      default: ;
    endcase
  end

endmodule

`default_nettype wire

FILE: rtl/core/ugrm_utf8_dec.sv
// UTF-8 decoder: accumulator and pending continuation count, one byte per
// cycle while stepped, with malformed sequence rejection. Depends on ugrm_pkg.
`default_nettype none

module ugrm_utf8_dec (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       step_i,
  input  logic                       clear_i,
  input  logic [7:0]                 byte_i,
  output logic                       cp_valid_o,
  output logic [ugrm_pkg::CP_W-1:0]  cp_o
);
  import ugrm_pkg::*;

  localparam logic [7:0] LEAD2_LO = 8'hC2;
  localparam logic [7:0] LEAD2_HI = 8'hDF;
  localparam logic [7:0] LEAD3_LO = 8'hE0;
  localparam logic [7:0] LEAD3_HI = 8'hEF;
  localparam logic [7:0] LEAD4_LO = 8'hF0;
  localparam logic [7:0] LEAD4_HI = 8'hF4;
  localparam logic [7:0] CONT_A0  = 8'hA0;
  localparam logic [7:0] CONT_90  = 8'h90;
  localparam logic [CP_W-1:0] ACC_SURR = 21'h00000D;
  localparam logic [CP_W-1:0] ACC_TOP  = 21'h000004;

  logic [CP_W-1:0] acc_q, acc_d, dec_acc, shifted;
  logic [1:0]      pend_q, pend_d, dec_pend;
  logic            bad;

  assign shifted = {acc_q[CP_W-7:0], byte_i[5:0]};
  assign bad = (acc_q == '0 && pend_q == 2'd2 && byte_i < CONT_A0)
            || (acc_q == '0 && pend_q == 2'd3 && byte_i < CONT_90)
            || (acc_q == ACC_SURR && pend_q == 2'd2 && byte_i >= CONT_A0)
            || (acc_q == ACC_TOP && pend_q == 2'd3 && byte_i >= CONT_90);

  always_comb begin
    dec_acc    = acc_q;
    dec_pend   = pend_q;
    cp_valid_o = 1'b0;
    cp_o       = CP_W'(byte_i);
    if (byte_i[7:6] == 2'b10) begin
      if (pend_q != 2'd0) begin
        if (bad) begin
          dec_acc  = '0;
          dec_pend = 2'd0;
        end else begin
          dec_pend = pend_q - 2'd1;
          if (pend_q == 2'd1) begin
            cp_o       = shifted;
            cp_valid_o = 1'b1;
            dec_acc    = '0;
          end else begin
            dec_acc = shifted;
          end
        end
      end
    end else begin
      dec_acc  = '0;
      dec_pend = 2'd0;
      if (!byte_i[7]) begin
        cp_valid_o = 1'b1;
      end else if (byte_i >= LEAD2_LO && byte_i <= LEAD2_HI) begin
        dec_acc  = CP_W'(byte_i[4:0]);
        dec_pend = 2'd1;
      end else if (byte_i >= LEAD3_LO && byte_i <= LEAD3_HI) begin
        dec_acc  = CP_W'(byte_i[3:0]);
        dec_pend = 2'd2;
      end else if (byte_i >= LEAD4_LO && byte_i <= LEAD4_HI) begin
        dec_acc  = CP_W'(byte_i[2:0]);
        dec_pend = 2'd3;
      end
    end
  end

  always_comb begin
    acc_d  = acc_q;
    pend_d = pend_q;
    if (clear_i) begin
      acc_d  = '0;
      pend_d = 2'd0;
    end else if (step_i) begin
      acc_d  = dec_acc;
      pend_d = dec_pend;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q  <= '0;
      pend_q <= 2'd0;
    end else begin
      acc_q  <= acc_d;
      pend_q <= pend_d;
    end
  end

`ifndef NO_ASSERTIONS
  a_idle_acc_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q == 2'd0 |-> acc_q == '0)
    else $error("accumulator not clear with no sequence pending");

  a_four_byte_lead: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q == 2'd3 |-> acc_q <= ACC_TOP)
    else $error("four-byte lead out of range");

  a_clear_drops: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clear_i |=> pend_q == 2'd0 && acc_q == '0)
    else $error("clear left a partial sequence");
`endif

endmodule

`default_nettype wire

FILE: rtl/core/ugrm_glyph_store.sv
// Width/offset and bitmap location memories, synchronous write and
// registered read. Depends on ugrm_pkg.
`default_nettype none

module ugrm_glyph_store #(
  parameter int GLYPH_SLOTS = 256
) (
  input  logic                  clk_i,
  input  ugrm_pkg::store_req_t  req_i,
  output ugrm_pkg::store_rsp_t  rsp_o
);
  import ugrm_pkg::*;

  localparam int WO_DEPTH = GLYPH_SLOTS;
  localparam int BL_DEPTH = GLYPH_SLOTS + 2;
  localparam int WO_AW    = $clog2(WO_DEPTH);
  localparam int BL_AW    = $clog2(BL_DEPTH);

  logic [WORD_W-1:0] wo_mem [WO_DEPTH];
  logic [WORD_W-1:0] bl_mem [BL_DEPTH];

  logic              wo_in_range, bl_in_range;
  logic [IDX_W-1:0]  nxt_idx;
  logic [WORD_W-1:0] wo_rd_q, bls_rd_q, bln_rd_q;

  assign wo_in_range = {1'b0, req_i.wr_addr} < 10'(WO_DEPTH);
  assign bl_in_range = {1'b0, req_i.wr_addr} < 10'(BL_DEPTH);
  assign nxt_idx     = IDX_W'(req_i.rd_idx) + 1'b1;

  always_ff @(posedge clk_i) begin
    if (req_i.wo_we && wo_in_range) begin
      wo_mem[req_i.wr_addr[WO_AW-1:0]] <= req_i.wr_data;
    end
    if (req_i.rd_en) begin
      wo_rd_q <= wo_mem[req_i.rd_idx[WO_AW-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.bl_we && bl_in_range) begin
      bl_mem[req_i.wr_addr[BL_AW-1:0]] <= req_i.wr_data;
    end
    if (req_i.rd_en) begin
      bls_rd_q <= bl_mem[BL_AW'(req_i.rd_idx)];
      bln_rd_q <= bl_mem[nxt_idx[BL_AW-1:0]];
    end
  end

  assign rsp_o.wo_word  = wo_rd_q;
  assign rsp_o.bl_start = bls_rd_q;
  assign rsp_o.bl_next  = bln_rd_q;

endmodule

`default_nettype wire
